// ===== src/tccs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the text console cursor/scroll unit.
// Depends on nothing; imported by every module of the block but tccs_ram.
package tccs_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int MOVE_LAST  = CELLS - COLUMNS - 1;
    localparam int BOTTOM     = (ROWS - 1) * COLUMNS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] BLANK          = 8'h20;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [CHAR_W-1:0] char_t;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_BLANK = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    // Store operation carried out after the optional cell write
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SCROLL,
        ACT_CLEAR,
        ACT_BLANK,
        ACT_READ
    } act_t;

    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        char_t wr_char;
        act_t  act;
        addr_t arg_addr;   // row base for blank, cell address for read
        logic  rd_ok;      // read address lies on the screen
        col_t  cursor_col;
        row_t  cursor_row;
    } cmd_t;

endpackage

// ===== src/text_console_cursor_scroll_unit.sv =====
`timescale 1ns / 1ps
// Top level of the text console cursor/scroll unit.
// Depends on tccs_pkg, tccs_front, tccs_cmd_fifo and tccs_back.

// A text console of 25 rows by 80 columns with a cursor. Each request gives
// exactly one result with the cursor after the request and, for a cell read,
// the cell contents. The cell store has one write port and one read port, and
// that port pair sets the time per request: a scroll or clear screen walks
// the store one cell per cycle, and blanking the cursor row walks that row.
// A two-entry command queue lets requests be taken while the store is busy.
// After reset the store is filled with spaces, one cell per cycle, and no
// request is taken until that pass is over.
module text_console_cursor_scroll_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code, cell_row, cell_col, zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // cursor_col, cursor_row, read_char, zero pad
);
    import tccs_pkg::*;

    logic  accept;
    logic  push;
    cmd_t  push_cmd;
    logic  fifo_not_full;
    logic  fifo_not_empty;
    cmd_t  head_cmd;
    logic  pop;
    logic  init_busy;
    col_t  out_col;
    row_t  out_row;
    char_t out_char;

    assign s_axis_tready = fifo_not_full && !init_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tccs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_t'(s_axis_tuser)),
        .char_code (s_axis_tdata[7:0]),
        .cell_row  (s_axis_tdata[12:8]),
        .cell_col  (s_axis_tdata[19:13]),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tccs_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .not_full  (fifo_not_full),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (fifo_not_empty)
    );

    tccs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (fifo_not_empty),
        .cmd_in    (head_cmd),
        .cmd_pop   (pop),
        .init_busy (init_busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_char  (out_char)
    );

    // Pack the result, first field lowest
    assign m_axis_tdata = {4'b0, out_char, out_row, out_col};

endmodule

// ===== src/tccs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/tccs_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on tccs_pkg.
module tccs_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tccs_pkg::cmd_t push_cmd,
    output logic           not_full,
    input  logic           pop,
    output tccs_pkg::cmd_t head_cmd,
    output logic           not_empty
);
    import tccs_pkg::*;

    cmd_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign not_full  = (count_reg != (PTR_W+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Store at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/tccs_front.sv =====
`timescale 1ns / 1ps
// Front part: owns the cursor, classifies each request and issues a store command.
// Depends on tccs_pkg.
module tccs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  tccs_pkg::req_t req_type,
    input  tccs_pkg::char_t char_code,
    input  tccs_pkg::row_t cell_row,
    input  tccs_pkg::col_t cell_col,
    output logic           push,
    output tccs_pkg::cmd_t push_cmd
);
    import tccs_pkg::*;

    col_t col_reg, col_next;
    row_t row_reg, row_next;
    cmd_t cmd;
    addr_t cur_addr;
    logic  last_row;

    assign cur_addr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign last_row = (row_reg == ROW_W'(ROWS - 1));

    // Work out the new cursor and the store command
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        cmd.wr_en    = 1'b0;
        cmd.wr_addr  = cur_addr;
        cmd.wr_char  = char_code;
        cmd.act      = ACT_NONE;
        cmd.arg_addr = ADDR_W'(32'(cell_row) * COLUMNS + 32'(cell_col));
        cmd.rd_ok    = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);
        case (req_type)
            REQ_PUT:
            begin
                if (char_code == CODE_NEWLINE)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        cmd.act = ACT_SCROLL;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else if (char_code == CODE_RETURN)
                begin
                    col_next = '0;
                end
                else if (char_code == CODE_BACKSPACE)
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            cmd.act = ACT_SCROLL;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            REQ_CLEAR:
            begin
                cmd.act  = ACT_CLEAR;
                col_next = '0;
                row_next = '0;
            end
            REQ_BLANK:
            begin
                cmd.act      = ACT_BLANK;
                cmd.arg_addr = ADDR_W'(32'(row_reg) * COLUMNS);
                col_next     = '0;
            end
            REQ_READ:
            begin
                cmd.act = ACT_READ;
            end
            default:
            begin
                cmd.act = ACT_NONE;
            end
        endcase
        cmd.cursor_col = col_next;
        cmd.cursor_row = row_next;
    end

    assign push     = accept;
    assign push_cmd = cmd;

    // Hold the cursor; update on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== src/tccs_back.sv =====
`timescale 1ns / 1ps
// Back part: carries out store commands on the cell store and presents results.
// Depends on tccs_pkg and tccs_ram.
module tccs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  tccs_pkg::cmd_t cmd_in,
    output logic           cmd_pop,
    output logic           init_busy,
    output logic           out_valid,
    input  logic           out_ready,
    output tccs_pkg::col_t out_col,
    output tccs_pkg::row_t out_row,
    output tccs_pkg::char_t out_char
);
    import tccs_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WRITE,
        ST_SCROLL,
        ST_DRAIN,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    addr_t  cnt_reg, cnt_next;
    addr_t  base_reg, base_next;
    addr_t  last_reg, last_next;
    cmd_t   cmd_reg, cmd_next;
    logic   mv_vld_reg, mv_vld_next;
    addr_t  mv_addr_reg, mv_addr_next;
    char_t  rdc_reg, rdc_next;
    logic   out_vld_reg, out_vld_next;
    col_t   out_col_reg, out_col_next;
    row_t   out_row_reg, out_row_next;
    char_t  out_char_reg, out_char_next;

    logic  ram_we;
    addr_t ram_waddr;
    char_t ram_wdata;
    addr_t ram_raddr;
    char_t ram_rdata;

    tccs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence the store operations
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        base_next     = base_reg;
        last_next     = last_reg;
        cmd_next      = cmd_reg;
        mv_vld_next   = 1'b0;
        mv_addr_next  = mv_addr_reg;
        rdc_next      = rdc_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_char_next = out_char_reg;
        cmd_pop       = 1'b0;
        // scroll copy is written in the cycle after its read
        ram_we        = mv_vld_reg;
        ram_waddr     = mv_addr_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = cmd_reg.arg_addr;

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = BLANK;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_in;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we    = cmd_reg.wr_en;
                ram_waddr = cmd_reg.wr_addr;
                ram_wdata = cmd_reg.wr_char;
                cnt_next  = '0;
                case (cmd_reg.act)
                    ACT_SCROLL:
                    begin
                        state_next = ST_SCROLL;
                    end
                    ACT_CLEAR:
                    begin
                        base_next  = '0;
                        last_next  = ADDR_W'(CELLS - 1);
                        state_next = ST_FILL;
                    end
                    ACT_BLANK:
                    begin
                        base_next  = cmd_reg.arg_addr;
                        last_next  = ADDR_W'(COLUMNS - 1);
                        state_next = ST_FILL;
                    end
                    ACT_READ:
                    begin
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCROLL:
            begin
                ram_raddr    = ADDR_W'(COLUMNS) + cnt_reg;
                mv_vld_next  = 1'b1;
                mv_addr_next = cnt_reg;
                if (cnt_reg == ADDR_W'(MOVE_LAST))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                cnt_next   = '0;
                base_next  = ADDR_W'(BOTTOM);
                last_next  = ADDR_W'(COLUMNS - 1);
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = base_reg + cnt_reg;
                ram_wdata = BLANK;
                if (cnt_reg == last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                rdc_next   = cmd_reg.rd_ok ? ram_rdata : '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_vld_next  = 1'b1;
                    out_col_next  = cmd_reg.cursor_col;
                    out_row_next  = cmd_reg.cursor_row;
                    out_char_next = (cmd_reg.act == ACT_READ) ? rdc_reg : '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            base_reg     <= '0;
            last_reg     <= '0;
            cmd_reg      <= '0;
            mv_vld_reg   <= 1'b0;
            mv_addr_reg  <= '0;
            rdc_reg      <= '0;
            out_vld_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_char_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            base_reg     <= base_next;
            last_reg     <= last_next;
            cmd_reg      <= cmd_next;
            mv_vld_reg   <= mv_vld_next;
            mv_addr_reg  <= mv_addr_next;
            rdc_reg      <= rdc_next;
            out_vld_reg  <= out_vld_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_char_reg <= out_char_next;
        end
    end

    assign init_busy = (state_reg == ST_INIT);
    assign out_valid = out_vld_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_char  = out_char_reg;

endmodule
